@@ design/assert_macros.svh @@
// shared assertion macros for the redactor design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sqlr_pkg.sv @@
package sqlr_pkg;

    localparam int NUM_TRIG     = 5;
    localparam int MAX_TRIG_LEN = 22;
    localparam int TAG_LEN      = 11;

    typedef logic [7:0] byte_t;

    // trigger phrases, lower case, right-justified in each word
    localparam int TRIG_LEN [NUM_TRIG] = '{17, 22, 19, 12, 6};
    localparam logic [MAX_TRIG_LEN*8-1:0] TRIG_TEXT [NUM_TRIG] = '{
        "unique constraint",
        "foreign key constraint",
        "not null constraint",
        "syntax error",
        "near \""
    };

    // replacement text
    localparam logic [TAG_LEN*8-1:0] TAG_TEXT = "<sql-error>";

    // sentence boundaries that end skipping
    localparam byte_t CHAR_PERIOD = 8'h2E;
    localparam byte_t CHAR_LF     = 8'h0A;
    localparam byte_t CHAR_CR     = 8'h0D;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_SCAN,
        ST_TAG,
        ST_FLUSH
    } seq_state_t;

    // per-cycle control of the hold chain
    typedef struct packed {
        logic append;
        logic shift;
    } cell_ctrl_t;

    // one result on its way to the output
    typedef struct packed {
        byte_t data;
        logic  valid;
        logic  last;
    } result_t;

    // fold ascii upper case to lower case
    function automatic byte_t fold_case(input byte_t c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // character i of trigger t, zero past its end
    function automatic byte_t trig_char(input int t, input int i);
        if (i >= TRIG_LEN[t])
        begin
            return 8'h00;
        end
        return TRIG_TEXT[t][(TRIG_LEN[t]-1-i)*8 +: 8];
    endfunction

    // character k of the replacement text
    function automatic byte_t tag_char(input logic [3:0] k);
        byte_t c;
        c = 8'h00;
        for (int j = 0; j < TAG_LEN; j++)
        begin
            if (k == 4'(j))
            begin
                c = TAG_TEXT[(TAG_LEN-1-j)*8 +: 8];
            end
        end
        return c;
    endfunction

endpackage

@@ design/sqlr_cell.sv @@
module sqlr_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                            clk,
    input  sqlr_pkg::cell_ctrl_t            ctrl,
    input  logic [CW-1:0]                   view_count,
    input  sqlr_pkg::byte_t                 new_byte,
    input  sqlr_pkg::byte_t                 nb_byte,
    output sqlr_pkg::byte_t                 w_byte,
    output logic [sqlr_pkg::NUM_TRIG-1:0]   match
);
    import sqlr_pkg::*;

    byte_t byte_reg;
    byte_t byte_next;
    byte_t folded;
    logic  here;
    logic  occupied;

    // incoming byte lands in the first free cell
    assign here     = ctrl.append && (view_count == CW'(IDX + 1));
    assign w_byte   = here ? new_byte : byte_reg;
    assign occupied = (CW'(IDX) < view_count);
    assign folded   = fold_case(w_byte);

    // compare against each trigger at this position
    for (genvar t = 0; t < NUM_TRIG; t++)
    begin : g_trig
        localparam byte_t EXP      = trig_char(t, IDX);
        localparam logic  IN_RANGE = (IDX < TRIG_LEN[t]);
        assign match[t] = !occupied || (IN_RANGE && (folded == EXP));
    end

    // take the neighbour's byte on a release, else keep own view
    assign byte_next = ctrl.shift ? nb_byte : w_byte;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

@@ design/sqlr_out_queue.sv @@
module sqlr_out_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sqlr_pkg::result_t   push_res,
    output logic                full,
    input  logic                pop,
    output sqlr_pkg::result_t   head,
    output logic                not_empty
);
    import sqlr_pkg::*;

    localparam int AW = $clog2(DEPTH);

    result_t       entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   fill_reg, fill_next;
    logic          do_pop;

    assign full      = (fill_reg == (AW+1)'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, do_pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

@@ design/sql_error_phrase_redactor.sv @@
// a byte that cannot start a trigger reaches an empty output queue's head in the cycle after
// acceptance; throughput: one byte per cycle while each byte gives at most one result
// the first result of a transaction is queued in its accepting cycle and each further result
// is queued later with no input taken: up to 21 for a flush, 10 for the replacement text
// input also stalls while the four-entry output queue is full
// reset: asynchronous active-low, empties the hold chain and output queue, copying mode
module sql_error_phrase_redactor #(
    parameter int HOLD_DEPTH = 21
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       last_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       end_of_message
);
    import sqlr_pkg::*;

    `include "assert_macros.svh"

    localparam int NCELL   = HOLD_DEPTH + 1;
    localparam int CW      = $clog2(HOLD_DEPTH + 2);
    localparam int Q_DEPTH = 4;

    seq_state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          skip_reg, skip_next;
    logic          last_reg, last_next;
    logic [3:0]    tag_idx_reg, tag_idx_next;

    cell_ctrl_t    ctrl;
    logic [CW-1:0] view_count;
    byte_t         w_byte_arr [NCELL];
    logic [NUM_TRIG-1:0] match_arr [NCELL];
    logic [NUM_TRIG-1:0] prefix;
    logic          full_any;
    logic          pre_any;

    logic          accept;
    logic          boundary;
    logic          drop;
    logic          append;
    logic          eval_go;
    logic          eval_last;

    logic          q_push;
    result_t       push_res;
    logic          q_full;
    result_t       q_head;
    logic          q_not_empty;

    // input handshake and skipping decision
    assign in_ready   = (state_reg == ST_RUN) && !q_full;
    assign accept     = in_valid && in_ready;
    assign boundary   = (in_byte == CHAR_PERIOD) || (in_byte == CHAR_LF) ||
                        (in_byte == CHAR_CR);
    assign drop       = skip_reg && !boundary;
    assign append     = accept && !drop;
    assign view_count = count_reg + CW'(append);

    // hold chain
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        byte_t nb;
        if (k < NCELL - 1)
        begin : g_mid
            assign nb = w_byte_arr[k+1];
        end
        else
        begin : g_end
            assign nb = 8'h00;
        end
        sqlr_cell #(
            .IDX (k),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .view_count (view_count),
            .new_byte   (in_byte),
            .nb_byte    (nb),
            .w_byte     (w_byte_arr[k]),
            .match      (match_arr[k])
        );
    end

    // prefix and full-match flags per trigger
    always_comb
    begin
        full_any = 1'b0;
        for (int t = 0; t < NUM_TRIG; t++)
        begin
            prefix[t] = 1'b1;
            for (int c = 0; c < NCELL; c++)
            begin
                prefix[t] = prefix[t] & match_arr[c][t];
            end
            if (prefix[t] && (view_count == CW'(TRIG_LEN[t])))
            begin
                full_any = 1'b1;
            end
        end
    end
    assign pre_any = |prefix;

    // sequencer: next state and results
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        skip_next    = skip_reg;
        last_next    = last_reg;
        tag_idx_next = tag_idx_reg;
        ctrl.append  = append;
        ctrl.shift   = 1'b0;
        q_push       = 1'b0;
        push_res     = '{data: 8'h00, valid: 1'b0, last: 1'b0};
        eval_go      = 1'b0;
        eval_last    = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (drop)
                    begin
                        // dropped byte; a last one gives a bare end mark
                        if (last_in)
                        begin
                            q_push        = 1'b1;
                            push_res.last = 1'b1;
                            skip_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        skip_next = 1'b0;
                        eval_go   = 1'b1;
                        eval_last = last_in;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!q_full)
                begin
                    eval_go   = 1'b1;
                    eval_last = last_reg;
                end
            end
            ST_FLUSH:
            begin
                // release everything held at the end of the message
                if (!q_full)
                begin
                    ctrl.shift     = 1'b1;
                    q_push         = 1'b1;
                    push_res.data  = w_byte_arr[0];
                    push_res.valid = 1'b1;
                    push_res.last  = (view_count == CW'(1));
                    count_next     = view_count - 1'b1;
                    if (view_count == CW'(1))
                    begin
                        state_next = ST_RUN;
                        last_next  = 1'b0;
                    end
                end
            end
            ST_TAG:
            begin
                // replacement text, one character a cycle while the output queue is not full
                if (!q_full)
                begin
                    q_push         = 1'b1;
                    push_res.data  = tag_char(tag_idx_reg);
                    push_res.valid = 1'b1;
                    tag_idx_next   = tag_idx_reg + 1'b1;
                    if (tag_idx_reg == 4'(TAG_LEN - 1))
                    begin
                        push_res.last = last_reg;
                        state_next    = ST_RUN;
                        tag_idx_next  = '0;
                        if (last_reg)
                        begin
                            skip_next = 1'b0;
                            last_next = 1'b0;
                        end
                    end
                end
            end
        endcase

        // one step of the match loop over the held view
        if (eval_go)
        begin
            if (full_any)
            begin
                q_push         = 1'b1;
                push_res.data  = tag_char(4'd0);
                push_res.valid = 1'b1;
                count_next     = '0;
                skip_next      = 1'b1;
                tag_idx_next   = 4'd1;
                last_next      = eval_last;
                state_next     = ST_TAG;
            end
            else if (pre_any && (view_count <= CW'(HOLD_DEPTH)) && !eval_last)
            begin
                count_next = view_count;
                state_next = ST_RUN;
                last_next  = 1'b0;
            end
            else
            begin
                ctrl.shift     = 1'b1;
                q_push         = 1'b1;
                push_res.data  = w_byte_arr[0];
                push_res.valid = 1'b1;
                push_res.last  = eval_last && (view_count == CW'(1));
                count_next     = view_count - 1'b1;
                last_next      = eval_last;
                if (view_count == CW'(1))
                begin
                    state_next = ST_RUN;
                    last_next  = 1'b0;
                end
                else if (pre_any && (view_count <= CW'(HOLD_DEPTH)))
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            count_reg   <= '0;
            skip_reg    <= 1'b0;
            last_reg    <= 1'b0;
            tag_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            skip_reg    <= skip_next;
            last_reg    <= last_next;
            tag_idx_reg <= tag_idx_next;
        end
    end

    // output queue decouples the result burst from the consumer
    sqlr_out_queue #(
        .DEPTH (Q_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_res  (push_res),
        .full      (q_full),
        .pop       (out_ready),
        .head      (q_head),
        .not_empty (q_not_empty)
    );

    assign out_valid      = q_not_empty;
    assign out_byte       = q_head.data;
    assign byte_valid     = q_head.valid;
    assign end_of_message = q_head.last;

    // checks
    `ASSERT_IMPLIES(a_skip_empty, clk, rst_n, skip_reg, count_reg == '0, "bytes held while skipping")
    `ASSERT_IMPLIES(a_tag_state, clk, rst_n, state_reg == ST_TAG, (count_reg == '0) && skip_reg, "tag without cleared hold")
    `ASSERT_IMPLIES(a_hold_bound, clk, rst_n, state_reg == ST_RUN, count_reg <= CW'(HOLD_DEPTH), "hold chain overrun")
    `ASSERT_NEXT(a_end_resets, clk, rst_n, q_push && push_res.last, (state_reg == ST_RUN) && (count_reg == '0) && !skip_reg, "state not reset after end")

endmodule

@@ dv/sql_error_phrase_redactor_tb.sv @@
`timescale 1ns / 1ps

module sql_error_phrase_redactor_tb;

    import sqlr_pkg::*;

    localparam int HOLD_BYTES   = 21;
    localparam int MAX_RESULTS  = 22;
    localparam int RANDOM_ITEMS = 146;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE       = 60;

    // one sanitised output transaction
    typedef struct packed {
        byte_t data;
        logic  has_byte;
        logic  eom;
    } redacted_t;

    // one directed input transaction, with an optional typed-in result
    typedef struct packed {
        byte_t     b;
        logic      lst;
        logic      typed;
        redacted_t want;
    } stim_row_t;

    localparam redacted_t NO_CHECK = '0;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       last_in = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_message;

    sql_error_phrase_redactor #(
        .HOLD_DEPTH(HOLD_BYTES)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_byte(in_byte),
        .last_in(last_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .byte_valid(byte_valid),
        .end_of_message(end_of_message)
    );

    // trigger phrases in lower case, and the text that replaces them
    string phrase [NUM_TRIG] = '{
        "unique constraint",
        "foreign key constraint",
        "not null constraint",
        "syntax error",
        "near \""
    };
    string replacement = "<sql-error>";

    // predictor state
    byte_t     held_q [HOLD_BYTES+1];
    int        held_n;
    bit        dropping;
    redacted_t step_out [$];

    // expected output transactions, oldest first
    redacted_t redacted_q [$];

    int  errors = 0;
    int  sent_n = 0;
    bit  calm = 1'b0;
    byte_t msg_bytes [$];

    // directed stimulus
    stim_row_t directed [24] = '{
        // single-byte messages at the extremes
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
        '{"n",   1'b1, 1'b1, '{"n",   1'b1, 1'b1}},
        '{"Z",   1'b1, 1'b1, '{"Z",   1'b1, 1'b1}},
        // mixed-case match, rest dropped, bare end mark
        '{"N",   1'b0, 1'b0, NO_CHECK},
        '{"e",   1'b0, 1'b0, NO_CHECK},
        '{"A",   1'b0, 1'b0, NO_CHECK},
        '{"r",   1'b0, 1'b0, NO_CHECK},
        '{" ",   1'b0, 1'b0, NO_CHECK},
        '{"\"",  1'b0, 1'b0, NO_CHECK},
        '{"q",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
        // held prefix that fails and is released
        '{"n",   1'b0, 1'b0, NO_CHECK},
        '{"o",   1'b0, 1'b0, NO_CHECK},
        '{"x",   1'b0, 1'b0, NO_CHECK},
        '{CHAR_PERIOD, 1'b1, 1'b1, '{CHAR_PERIOD, 1'b1, 1'b1}},
        // match, then a line feed ends the dropping and a carriage return ends the message
        '{"N",   1'b0, 1'b0, NO_CHECK},
        '{"E",   1'b0, 1'b0, NO_CHECK},
        '{"A",   1'b0, 1'b0, NO_CHECK},
        '{"R",   1'b0, 1'b0, NO_CHECK},
        '{" ",   1'b0, 1'b0, NO_CHECK},
        '{"\"",  1'b0, 1'b0, NO_CHECK},
        '{"z",   1'b0, 1'b0, NO_CHECK},
        '{CHAR_LF, 1'b0, 1'b1, '{CHAR_LF, 1'b1, 1'b0}},
        '{CHAR_CR, 1'b1, 1'b1, '{CHAR_CR, 1'b1, 1'b1}}
    };

    // ascii-only case folding
    function automatic byte_t lower_ascii(byte_t c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic bit held_matches(int t);
        if (held_n > phrase[t].len())
        begin
            return 1'b0;
        end
        for (int i = 0; i < held_n; i++)
        begin
            if (lower_ascii(held_q[i]) != byte_t'(phrase[t][i]))
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void push_result(byte_t b);
        if (step_out.size() < MAX_RESULTS)
        begin
            step_out.push_back(redacted_t'{b, 1'b1, 1'b0});
        end
    endfunction

    function automatic void release_front();
        push_result(held_q[0]);
        for (int i = 0; i < HOLD_BYTES; i++)
        begin
            held_q[i] = held_q[i+1];
        end
        held_n--;
    endfunction

    function automatic void clear_state();
        foreach (held_q[i])
        begin
            held_q[i] = 8'h00;
        end
        held_n   = 0;
        dropping = 1'b0;
    endfunction

    // works out the output of one message byte; returns 1 unless the byte was dropped
    function automatic bit redact_byte(byte_t c, bit lst);
        bit        taken;
        bit        whole;
        bit        partial;
        redacted_t r;
        taken = 1'b1;
        step_out.delete();
        if (dropping)
        begin
            if (c == CHAR_PERIOD || c == CHAR_LF || c == CHAR_CR)
            begin
                dropping = 1'b0;
            end
            else
            begin
                taken = 1'b0;
            end
        end
        if (taken)
        begin
            if (held_n > HOLD_BYTES)
            begin
                held_n = HOLD_BYTES;
            end
            held_q[held_n] = c;
            held_n++;
            while (held_n > 0)
            begin
                whole   = 1'b0;
                partial = 1'b0;
                for (int t = 0; t < NUM_TRIG; t++)
                begin
                    if (held_matches(t))
                    begin
                        partial = 1'b1;
                        if (held_n == phrase[t].len())
                        begin
                            whole = 1'b1;
                        end
                    end
                end
                if (whole)
                begin
                    for (int k = 0; k < replacement.len(); k++)
                    begin
                        push_result(byte_t'(replacement[k]));
                    end
                    held_n   = 0;
                    dropping = 1'b1;
                    break;
                end
                if (partial && held_n <= HOLD_BYTES)
                begin
                    break;
                end
                release_front();
            end
        end
        // end of message: flush, mark the final transaction, back to reset state
        if (lst)
        begin
            while (held_n > 0)
            begin
                release_front();
            end
            if (step_out.size() == 0)
            begin
                step_out.push_back(redacted_t'{8'h00, 1'b0, 1'b1});
            end
            else
            begin
                r = step_out.pop_back();
                r.eom = 1'b1;
                step_out.push_back(r);
            end
            clear_state();
        end
        return taken;
    endfunction

    // mostly short gaps, a few long ones, none in calm stretches
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (calm || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    // drives one input transaction and records what it should produce
    task automatic send_byte(input byte_t b, input bit lst, input bit typed,
                             input redacted_t want);
        int g;
        g = idle_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        last_in  <= lst;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end
        // accepted at the coming edge
        void'(redact_byte(b, lst));
        sent_n++;
        if (typed)
        begin
            redacted_q.push_back(want);
        end
        else
        begin
            foreach (step_out[i])
            begin
                redacted_q.push_back(step_out[i]);
            end
        end
        @(posedge clk);
    endtask

    // clock
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout, %0d transactions still expected", $time, redacted_q.size());
        $display("Regression FAIL");
        $finish;
    end

    // receiver stalls
    initial
    begin
        int s;
        forever
        begin
            @(posedge clk);
            s = idle_len();
            if (s > 0)
            begin
                out_ready <= 1'b0;
                repeat (s) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(12, 1) - 1) @(posedge clk);
        end
    end

    // output checker
    always @(negedge clk)
    begin
        redacted_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (redacted_q.size() == 0)
            begin
                $display("%0t: unexpected transaction: expected none, got byte %02h valid %0b end %0b",
                         $time, out_byte, byte_valid, end_of_message);
                errors++;
            end
            else
            begin
                want = redacted_q.pop_front();
                if (out_byte !== want.data)
                begin
                    $display("%0t: out_byte expected %02h got %02h", $time, want.data, out_byte);
                    errors++;
                end
                if (byte_valid !== want.has_byte)
                begin
                    $display("%0t: byte_valid expected %0b got %0b",
                             $time, want.has_byte, byte_valid);
                    errors++;
                end
                if (end_of_message !== want.eom)
                begin
                    $display("%0t: end_of_message expected %0b got %0b",
                             $time, want.eom, end_of_message);
                    errors++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int    t;
        int    cut;
        int    pick;
        int    n_fill;
        byte_t c;
        clear_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        for (int r = 0; r < $size(directed); r++)
        begin
            send_byte(directed[r].b, directed[r].lst, directed[r].typed, directed[r].want);
        end

        // random messages built from whole, broken and absent trigger phrases
        sent_n = 0;
        while (sent_n < RANDOM_ITEMS)
        begin
            msg_bytes.delete();
            calm = ($urandom_range(4) == 0);
            repeat ($urandom_range(5, 1))
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    // phrase in random case, cut short and followed by a stray byte if broken
                    t   = $urandom_range(NUM_TRIG - 1);
                    cut = (pick < 35) ? phrase[t].len() : $urandom_range(phrase[t].len() - 1, 1);
                    for (int i = 0; i < cut; i++)
                    begin
                        c = byte_t'(phrase[t][i]);
                        if (c >= "a" && c <= "z" && $urandom_range(1) == 1)
                        begin
                            c = c - 8'h20;
                        end
                        msg_bytes.push_back(c);
                    end
                    if (pick >= 35)
                    begin
                        msg_bytes.push_back(byte_t'($urandom_range(255)));
                    end
                end
                else if (pick < 85)
                begin
                    // filler text
                    n_fill = $urandom_range(6, 1);
                    for (int i = 0; i < n_fill; i++)
                    begin
                        case ($urandom_range(9))
                            0, 1, 2, 3, 4, 5:
                            begin
                                c = byte_t'($urandom_range("z", "a"));
                                if ($urandom_range(1) == 1)
                                begin
                                    c = c - 8'h20;
                                end
                            end
                            6:       c = " ";
                            7:       c = byte_t'($urandom_range(255));
                            default: c = byte_t'($urandom_range(8'h7E, 8'h21));
                        endcase
                        msg_bytes.push_back(c);
                    end
                end
                else if (pick < 95)
                begin
                    // sentence boundary
                    case ($urandom_range(2))
                        0:       msg_bytes.push_back(CHAR_PERIOD);
                        1:       msg_bytes.push_back(CHAR_LF);
                        default: msg_bytes.push_back(CHAR_CR);
                    endcase
                end
                else
                begin
                    msg_bytes.push_back(byte_t'($urandom_range(255)));
                end
            end
            foreach (msg_bytes[i])
            begin
                send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, NO_CHECK);
            end
        end

        // drain and settle
        in_valid <= 1'b0;
        while (redacted_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && redacted_q.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
